### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, off during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define PPM_NEVER(label, cond, msg) \
  `PPM_ASSERT(label, !(cond), msg)

`endif

### src/ppm_pkg.sv
// ---------------------------------------------------------------------------
// ppm_pkg
// types and constants shared by the proximity point merge modules
// ---------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

  localparam int PPM_MAX_ENTRIES = 64;

  localparam int COORD_W  = 24;
  localparam int WEIGHT_W = 16;
  localparam int RADIUS_W = 23;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  // blend divider: |mean*w + p| needs COORD_W + DEN_W bits
  localparam int DEN_W = WEIGHT_W + 1;
  localparam int NUM_W = COORD_W + DEN_W;
  localparam int PROD_W = COORD_W + DEN_W;

  // squared distance widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int SUM_W  = SQ_W + 1;
  localparam int R2_W   = 2 * RADIUS_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = '1;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_READ = 1'b1
  } ppm_kind_t;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [INDEX_W-1:0]        entry_index;
  } ppm_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        joined_count;
    logic                      appended;
    logic                      dropped_full;
    logic [COUNT_W-1:0]        entries_used;
    logic signed [COORD_W-1:0] read_x;
    logic signed [COORD_W-1:0] read_y;
    logic [WEIGHT_W-1:0]       read_weight;
    logic                      read_valid;
  } ppm_out_t;

  // classified item between front and back
  typedef struct packed {
    logic                      is_read;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [INDEX_W-1:0]        idx;
  } ppm_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [WEIGHT_W-1:0]       w;
  } ppm_entry_t;

  typedef struct packed {
    logic      valid;
    ppm_item_t item;
  } ppm_queue_t;

endpackage

`default_nettype wire

### src/ppm_front.sv
// ---------------------------------------------------------------------------
// ppm_front
// accepts input transfers, classifies them and holds them in a two-entry queue
// ---------------------------------------------------------------------------
`default_nettype none

module ppm_front import ppm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  ppm_in_t    in_data,
  output ppm_queue_t head,
  input  logic       pop
);

  ppm_item_t slot [2];
  logic [1:0] count;
  logic       push;
  ppm_item_t  item;

  always_comb begin
    item.is_read = (in_data.kind == KIND_READ);
    item.x       = in_data.point_x;
    item.y       = in_data.point_y;
    item.idx     = in_data.entry_index;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign head     = '{valid: (count != 2'd0), item: slot[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    // slot 0 is the head, slot 1 the tail
    if (pop) begin
      slot[0] <= slot[1];
      if (push && count == 2'd1) begin
        slot[0] <= item;
      end
      if (push && count == 2'd2) begin
        slot[1] <= item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot[0] <= item;
      end else begin
        slot[1] <= item;
      end
    end
  end

endmodule

`default_nettype wire

### src/ppm_div.sv
// ---------------------------------------------------------------------------
// ppm_div
// serial restoring divider, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
`default_nettype none

module ppm_div import ppm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      neg,
  input  logic [NUM_W-1:0]          mag,
  input  logic [DEN_W-1:0]          den,
  output logic                      done,
  output logic signed [COORD_W-1:0] quo
);

  localparam int STEP_W = $clog2(COORD_W + 1);

  logic [DEN_W-1:0]   rem;
  logic [COORD_W-1:0] qbits;
  logic [DEN_W-1:0]   den_r;
  logic               neg_r;
  logic [STEP_W-1:0]  step;
  logic [DEN_W:0]     trial;
  logic               take;

  // quotient fits COORD_W bits, so the high part is already below den
  assign trial = {rem, qbits[COORD_W-1]};
  assign take  = (trial >= {1'b0, den_r});
  assign quo   = neg_r ? -$signed(qbits) : $signed(qbits);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= STEP_W'(COORD_W);
      end else if (step != '0) begin
        step <= step - 1'b1;
        done <= (step == STEP_W'(1));
      end
    end
    if (start) begin
      rem   <= mag[NUM_W-1:COORD_W];
      qbits <= mag[COORD_W-1:0];
      den_r <= den;
      neg_r <= neg;
    end else if (step != '0) begin
      rem   <= take ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      qbits <= {qbits[COORD_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

### src/ppm_back.sv
// ---------------------------------------------------------------------------
// ppm_back
// walks the entry table for add items, serves reads, owns the result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ppm_back import ppm_pkg::*; #(
  parameter int MAX_ENTRIES = PPM_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_data,
  input  ppm_queue_t          head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ppm_out_t            out_data
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REPLY, ST_SQ, ST_TEST, ST_NUM, ST_DIV, ST_FINISH, ST_EMIT
  } state_t;

  state_t state;

  ppm_entry_t mem [MAX_ENTRIES];
  ppm_entry_t mem_rd;
  logic       mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  ppm_entry_t mem_wdata;

  logic [RADIUS_W-1:0] radius;
  logic [R2_W-1:0]     r2;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] idx, idx_next, joined;
  logic             last;
  logic             append;
  ppm_item_t        cur;
  ppm_entry_t       ent;
  logic             rd_ok;
  logic [SQ_W-1:0]  sqx, sqy;
  logic             match;
  logic signed [PROD_W-1:0] prodx, prody;
  logic signed [PROD_W:0]   numx, numy;
  logic [DEN_W-1:0] den;
  logic [WEIGHT_W-1:0] w_inc;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [2*DIFF_W-1:0] dx2, dy2;
  logic div_start, div_x_done, div_y_done;
  logic signed [COORD_W-1:0] qx, qy;
  ppm_out_t res;
  logic emit_go;

  assign idx_next = idx + 1'b1;
  assign last     = (idx_next >= fill_count);
  assign append   = (joined == '0) && (fill_count < CNT_W'(MAX_ENTRIES));
  assign match    = (SUM_W'(sqx) + SUM_W'(sqy)) < SUM_W'(r2);
  assign den      = {1'b0, ent.w} + 1'b1;
  assign w_inc    = (ent.w == WEIGHT_SAT) ? ent.w : ent.w + 1'b1;
  assign numx     = (PROD_W + 1)'(prodx) + (PROD_W + 1)'(cur.x);
  assign numy     = (PROD_W + 1)'(prody) + (PROD_W + 1)'(cur.y);
  assign div_start = (state == ST_NUM);
  assign dx       = DIFF_W'(cur.x) - DIFF_W'(mem_rd.x);
  assign dy       = DIFF_W'(cur.y) - DIFF_W'(mem_rd.y);
  assign dx2      = dx * dx;
  assign dy2      = dy * dy;
  assign emit_go  = !out_valid || !out_stall;

  ppm_div u_div_x (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .neg  (numx[PROD_W]),
    .mag  (numx[PROD_W] ? NUM_W'(-numx) : NUM_W'(numx)),
    .den  (den),
    .done (div_x_done),
    .quo  (qx)
  );

  ppm_div u_div_y (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .neg  (numy[PROD_W]),
    .mag  (numy[PROD_W] ? NUM_W'(-numy) : NUM_W'(numy)),
    .den  (den),
    .done (div_y_done),
    .quo  (qy)
  );

  // table port control
  always_comb begin
    pop       = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = '{x: qx, y: qy, w: w_inc};
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop    = 1'b1;
          mem_re = 1'b1;
          if (head.item.is_read) begin
            mem_raddr = AW'(head.item.idx);
          end
        end
      end
      ST_TEST: begin
        if (!match && !last) begin
          mem_re    = 1'b1;
          mem_raddr = idx_next[AW-1:0];
        end
      end
      ST_DIV: begin
        if (div_x_done) begin
          mem_we = 1'b1;
          if (!last) begin
            mem_re    = 1'b1;
            mem_raddr = idx_next[AW-1:0];
          end
        end
      end
      ST_FINISH: begin
        if (append) begin
          mem_we    = 1'b1;
          mem_waddr = fill_count[AW-1:0];
          mem_wdata = '{x: cur.x, y: cur.y, w: WEIGHT_W'(1)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    r2 <= R2_W'(radius * radius);
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
      radius     <= '0;
    end else begin
      if (cfg_we) begin
        radius <= cfg_data;
      end
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            cur    <= head.item;
            idx    <= '0;
            joined <= '0;
            rd_ok  <= CMP_W'(head.item.idx) < CMP_W'(fill_count);
            if (head.item.is_read) begin
              state <= ST_REPLY;
            end else if (fill_count == '0) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SQ;
            end
          end
        end
        ST_REPLY: begin
          res <= '{entries_used: COUNT_W'(fill_count),
                   read_x:       rd_ok ? mem_rd.x : '0,
                   read_y:       rd_ok ? mem_rd.y : '0,
                   read_weight:  rd_ok ? mem_rd.w : '0,
                   read_valid:   rd_ok,
                   default:      '0};
          state <= ST_EMIT;
        end
        ST_SQ: begin
          ent   <= mem_rd;
          sqx   <= SQ_W'(dx2);
          sqy   <= SQ_W'(dy2);
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (match) begin
            prodx <= ent.x * $signed({1'b0, ent.w});
            prody <= ent.y * $signed({1'b0, ent.w});
            state <= ST_NUM;
          end else if (last) begin
            state <= ST_FINISH;
          end else begin
            idx   <= idx_next;
            state <= ST_SQ;
          end
        end
        ST_NUM: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_x_done) begin
            joined <= joined + 1'b1;
            if (last) begin
              state <= ST_FINISH;
            end else begin
              idx   <= idx_next;
              state <= ST_SQ;
            end
          end
        end
        ST_FINISH: begin
          res <= '{joined_count: COUNT_W'(joined),
                   appended:     append,
                   dropped_full: (joined == '0) && !append,
                   entries_used: append ? COUNT_W'(fill_count + 1'b1)
                                        : COUNT_W'(fill_count),
                   default:      '0};
          if (append) begin
            fill_count <= fill_count + 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PPM_ASSERT(a_fill_bound, fill_count <= CNT_W'(MAX_ENTRIES), "fill count beyond table size")
  `PPM_ASSERT(a_fill_step, fill_count != $past(fill_count) |-> fill_count == $past(fill_count) + 1'b1, "fill count moved by more than one")
  `PPM_NEVER(a_div_pair, div_x_done != div_y_done, "x and y dividers out of step")
  `PPM_NEVER(a_app_drop, out_valid && out_data.appended && out_data.dropped_full, "result both appended and dropped")

endmodule

`default_nettype wire

### src/proximity_point_merge_unit.sv
// ---------------------------------------------------------------------------
// proximity_point_merge_unit
// merges nearby 2-D points into a table of running means with weights
// ---------------------------------------------------------------------------
// read item: held in the front queue, then ST_REPLY and ST_EMIT in the back; add
//   item: ST_SQ, ST_TEST per entry, ST_NUM, ST_DIV per merge, then ST_FINISH, ST_EMIT
// back end: one item at a time; the entry walk, one table read per entry over a
//   single read port, sets the rate
// reset: rst is synchronous; empties the queue and the table, clears merge_radius
// ---------------------------------------------------------------------------
`default_nettype none

module proximity_point_merge_unit import ppm_pkg::*; #(
  parameter int MAX_ENTRIES = PPM_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  // merge_radius register
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_data,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  ppm_in_t             in_data,
  // results, one per item
  output logic                out_valid,
  input  logic                out_stall,
  output ppm_out_t            out_data
);

  // head of the queue and its pop, between front and back
  ppm_queue_t head;
  logic       pop;

  // front: takes a transfer whenever the queue has room
  ppm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .head    (head),
    .pop     (pop)
  );

  // back: table walk, mean update, result register
  ppm_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
